FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks on the rising clock edge, disabled while in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SAME(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_SAME(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: src/arjb_pkg.sv
// ----------------------------------------------------------------------------
// arjb_pkg
// shared constants and types of the audio ring jitter buffer
// ----------------------------------------------------------------------------
package arjb_pkg;

	// ring depth is a power of two
	localparam int RING_DEPTH    = 8192;
	localparam int MAX_READ      = 64;
	localparam int ADDR_W        = $clog2(RING_DEPTH);
	localparam int AV_W          = ADDR_W + 1;
	localparam int N_W           = 7;
	localparam int BLK_W         = 16;
	localparam int TM_W          = BLK_W + 2;
	localparam int DATA_W        = 32;
	localparam int POS_W         = 64;
	localparam int CFG_IDX_W     = 2;
	localparam int QDEPTH        = 4;
	localparam int QPTR_W        = $clog2(QDEPTH);
	localparam int DEFAULT_BLOCK = 512;
	localparam int LEAD_MULT     = 3;
	localparam int REQ_MULT      = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MUTE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RUN    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK  = 2'd3;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	typedef struct packed {
		logic              is_read;
		logic [DATA_W-1:0] data;
		logic [ADDR_W-1:0] addr;
		logic [N_W-1:0]    copy;
		logic [N_W-1:0]    count;
	} op_t;

	typedef struct packed {
		logic valid;
		logic full;
	} q_status_t;

endpackage

FILE: src/audio_ring_jitter_buffer.sv
// ----------------------------------------------------------------------------
// audio_ring_jitter_buffer
// mono sample ring with one writer and one reader
//
// a command is taken when start is high and busy is low. command 0 stores
// sample_in at the write count and advances it; command 1 asks for
// frame_count frames (capped at 64) and yields that many results on sample_out,
// each valid for one cycle with strobe, the final one with last. silence,
// missing data and muted or stopped states give zero samples.
// writes are taken one per cycle while the four-entry operation queue has
// room. a read holds busy while the reader is placed behind the writer; the
// back end then streams it from the ring through a registered read, one
// sample per cycle, paced by the single read port of the ring. a silenced
// read skips placement and is queued at once. writes that follow a read
// queue up behind its stream. the receiver cannot stall: every result is
// shown for exactly one cycle. reset clears both positions, mute, run and
// source and sets block to 512; ring contents stay undefined until written.
// registers go through cfg_we, cfg_index and cfg_wdata; the user must write
// them only while no command is outstanding, which the module does not check.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module audio_ring_jitter_buffer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           command,
	input  logic [arjb_pkg::DATA_W-1:0]    sample_in,
	input  logic [arjb_pkg::N_W-1:0]       frame_count,
	input  logic                           resync,
	input  logic                           cfg_we,
	input  logic [arjb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [arjb_pkg::BLK_W-1:0]     cfg_wdata,
	output logic [arjb_pkg::DATA_W-1:0]    sample_out,
	output logic                           last,
	output logic                           strobe
);
	import arjb_pkg::*;

	q_status_t q_status;
	op_t       push_op;
	op_t       head;
	logic      push;
	logic      pop;

	arjb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.sample_in   (sample_in),
		.frame_count (frame_count),
		.resync      (resync),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.q_status    (q_status),
		.push        (push),
		.push_op     (push_op)
	);

	arjb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_op  (push_op),
		.pop      (pop),
		.head     (head),
		.q_status (q_status)
	);

	arjb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_status   (q_status),
		.head       (head),
		.pop        (pop),
		.sample_out (sample_out),
		.last       (last),
		.strobe     (strobe)
	);

	`ASSERT_SAME(a_push_room, push, !q_status.full, "operation pushed into a full queue")
	`ASSERT_SAME(a_write_queued, start && !busy && command == CMD_WRITE, push, "write not queued")
	`ASSERT_SAME(a_last_strobed, last, strobe, "last without strobe")
	`ASSERT_NEXT(a_push_seen, push && !pop, q_status.valid, "queued operation lost")

endmodule

FILE: src/arjb_front.sv
// ----------------------------------------------------------------------------
// arjb_front
// accepts commands, tracks write and read positions, places the reader
// and hands ring operations to the queue
// ----------------------------------------------------------------------------
module arjb_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              command,
	input  logic [arjb_pkg::DATA_W-1:0]       sample_in,
	input  logic [arjb_pkg::N_W-1:0]          frame_count,
	input  logic                              resync,
	input  logic                              cfg_we,
	input  logic [arjb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [arjb_pkg::BLK_W-1:0]        cfg_wdata,
	input  arjb_pkg::q_status_t               q_status,
	output logic                              push,
	output arjb_pkg::op_t                     push_op
);
	import arjb_pkg::*;

	localparam logic [3:0] F_IDLE  = 4'd0;
	localparam logic [3:0] F_TGT   = 4'd1;
	localparam logic [3:0] F_LEAD  = 4'd2;
	localparam logic [3:0] F_PLACE = 4'd3;
	localparam logic [3:0] F_DIFF  = 4'd4;
	localparam logic [3:0] F_CLAMP = 4'd5;
	localparam logic [3:0] F_MAX   = 4'd6;
	localparam logic [3:0] F_FIN   = 4'd7;
	localparam logic [3:0] F_PUSH  = 4'd8;

	localparam logic [TM_W-1:0]  HALF   = TM_W'(RING_DEPTH / 2);
	localparam logic [POS_W-1:0] CAP64  = POS_W'(RING_DEPTH);
	localparam logic [AV_W-1:0]  CAP_AV = AV_W'(RING_DEPTH);

	logic [3:0]        state_q;
	logic              mute_q;
	logic              run_q;
	logic              src_q;
	logic [BLK_W-1:0]  blk_q;
	logic [POS_W-1:0]  wp_q;
	logic [POS_W-1:0]  rp_q;
	logic [POS_W-1:0]  rp_w_q;
	logic [POS_W-1:0]  lead_q;
	logic [POS_W-1:0]  diff_q;
	logic [ADDR_W-1:0] target_q;
	logic [AV_W-1:0]   avail_q;
	logic [N_W-1:0]    n_q;
	logic              wp_gt_t_q;

	logic              accept;
	logic              silent;
	logic [N_W-1:0]    n_sat;
	logic [BLK_W-1:0]  block;
	logic [TM_W-1:0]   t3;
	logic [TM_W-1:0]   t2;
	logic [TM_W-1:0]   tmax;
	logic [TM_W-1:0]   tcap;
	logic              wp_gt_t;
	logic [AV_W-1:0]   tn;
	logic              wp_gt_tn;
	logic [AV_W-1:0]   maxlead;
	logic [N_W-1:0]    copy;

	assign busy   = (state_q != F_IDLE) || q_status.full;
	assign accept = start && !busy;
	assign silent = mute_q || !run_q || !src_q;
	assign n_sat  = (frame_count > N_W'(MAX_READ)) ? N_W'(MAX_READ) : frame_count;

	// lead target
	assign block = (blk_q == '0) ? BLK_W'(DEFAULT_BLOCK) : blk_q;
	assign t3    = TM_W'(block) * TM_W'(LEAD_MULT);
	assign t2    = TM_W'(n_q) * TM_W'(REQ_MULT);
	assign tmax  = (t3 > t2) ? t3 : t2;
	assign tcap  = (tmax > HALF) ? HALF : tmax;

	assign wp_gt_t  = (wp_q[POS_W-1:ADDR_W] != '0) || (wp_q[ADDR_W-1:0] > target_q);
	assign tn       = AV_W'(target_q) + AV_W'(n_q);
	assign wp_gt_tn = (wp_q[POS_W-1:AV_W] != '0) || (wp_q[AV_W-1:0] > tn);
	assign maxlead  = {target_q, 1'b0};
	assign copy     = (avail_q > AV_W'(n_q)) ? n_q : avail_q[N_W-1:0];

	always_comb begin
		push    = 1'b0;
		push_op = '0;
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					if (command == CMD_WRITE) begin
						push         = 1'b1;
						push_op.data = sample_in;
						push_op.addr = wp_q[ADDR_W-1:0];
					end else if (n_sat != '0 && silent) begin
						push            = 1'b1;
						push_op.is_read = 1'b1;
						push_op.count   = n_sat;
					end
				end
			end
			F_PUSH: begin
				push            = 1'b1;
				push_op.is_read = 1'b1;
				push_op.addr    = rp_w_q[ADDR_W-1:0];
				push_op.copy    = copy;
				push_op.count   = n_q;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			mute_q  <= 1'b0;
			run_q   <= 1'b0;
			src_q   <= 1'b0;
			blk_q   <= BLK_W'(DEFAULT_BLOCK);
			wp_q    <= '0;
			rp_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MUTE:   mute_q <= cfg_wdata[0];
					REG_RUN:    run_q  <= cfg_wdata[0];
					REG_SOURCE: src_q  <= cfg_wdata[0];
					REG_BLOCK:  blk_q  <= cfg_wdata;
					default:    blk_q  <= blk_q;
				endcase
			end
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						if (command == CMD_WRITE) begin
							wp_q <= wp_q + 1'b1;
						end else if (n_sat != '0 && !silent) begin
							state_q <= F_TGT;
						end
					end
				end
				F_TGT:   state_q <= F_LEAD;
				F_LEAD:  state_q <= F_PLACE;
				F_PLACE: state_q <= F_DIFF;
				F_DIFF:  state_q <= F_CLAMP;
				F_CLAMP: state_q <= F_MAX;
				F_MAX:   state_q <= F_FIN;
				F_FIN:   state_q <= F_PUSH;
				F_PUSH: begin
					rp_q    <= rp_w_q + POS_W'(copy);
					state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// working registers of the reader placement
	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				n_q    <= n_sat;
				rp_w_q <= resync ? '0 : rp_q;
			end
			F_TGT: begin
				target_q <= tcap[ADDR_W-1:0];
			end
			F_LEAD: begin
				wp_gt_t_q <= wp_gt_t;
				lead_q    <= wp_gt_t ? (wp_q - POS_W'(target_q)) : '0;
			end
			F_PLACE: begin
				if (rp_w_q == '0 || rp_w_q > wp_q) begin
					rp_w_q <= lead_q;
				end
			end
			F_DIFF: begin
				diff_q <= wp_q - rp_w_q;
			end
			F_CLAMP: begin
				if (diff_q > CAP64) begin
					rp_w_q  <= wp_q - CAP64;
					avail_q <= CAP_AV;
				end else begin
					avail_q <= diff_q[AV_W-1:0];
				end
			end
			F_MAX: begin
				if (avail_q > maxlead) begin
					rp_w_q  <= lead_q;
					avail_q <= wp_gt_t_q ? AV_W'(target_q) : wp_q[AV_W-1:0];
				end
			end
			F_FIN: begin
				if (avail_q != '0 && avail_q < AV_W'(n_q) && wp_gt_tn) begin
					rp_w_q  <= lead_q;
					avail_q <= AV_W'(target_q);
				end
			end
			default: begin
				n_q <= n_q;
			end
		endcase
	end

endmodule

FILE: src/arjb_queue.sv
// ----------------------------------------------------------------------------
// arjb_queue
// short first-in first-out queue of ring operations
// ----------------------------------------------------------------------------
module arjb_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  arjb_pkg::op_t       push_op,
	input  logic                pop,
	output arjb_pkg::op_t       head,
	output arjb_pkg::q_status_t q_status
);
	import arjb_pkg::*;

	op_t               entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign head           = entry_q[rd_ptr_q];
	assign q_status.valid = (count_q != '0);
	assign q_status.full  = (count_q == (QPTR_W+1)'(QDEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

FILE: src/arjb_back.sv
// ----------------------------------------------------------------------------
// arjb_back
// sample ring memory: stores writes and streams read requests
// ----------------------------------------------------------------------------
module arjb_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  arjb_pkg::q_status_t         q_status,
	input  arjb_pkg::op_t               head,
	output logic                        pop,
	output logic [arjb_pkg::DATA_W-1:0] sample_out,
	output logic                        last,
	output logic                        strobe
);
	import arjb_pkg::*;

	logic [DATA_W-1:0] ring [RING_DEPTH];

	logic              active_q;
	logic [N_W-1:0]    k_q;
	logic [N_W-1:0]    n_q;
	logic [N_W-1:0]    copy_q;
	logic [ADDR_W-1:0] base_q;
	logic              strobe_s2;
	logic              last_s2;
	logic              real_s2;
	logic [DATA_W-1:0] mem_q;

	logic              final_beat;
	logic [ADDR_W-1:0] rd_addr;

	assign final_beat = active_q && (k_q == N_W'(n_q - 1'b1));
	assign pop        = q_status.valid && (!active_q || final_beat);
	assign rd_addr    = base_q + ADDR_W'(k_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			k_q       <= '0;
			strobe_s2 <= 1'b0;
			last_s2   <= 1'b0;
		end else begin
			strobe_s2 <= active_q;
			last_s2   <= final_beat;
			if (pop && head.is_read) begin
				active_q <= 1'b1;
				k_q      <= '0;
			end else if (final_beat) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.is_read) begin
			n_q    <= head.count;
			copy_q <= head.copy;
			base_q <= head.addr;
		end
		real_s2 <= (k_q < copy_q);
	end

	always_ff @(posedge clk) begin
		if (pop && !head.is_read) begin
			ring[head.addr] <= head.data;
		end
	end

	always_ff @(posedge clk) begin
		mem_q <= ring[rd_addr];
	end

	assign sample_out = real_s2 ? mem_q : '0;
	assign last       = last_s2;
	assign strobe     = strobe_s2;

endmodule
